// File: design/apip_pkg.sv
// Shared record IDs, result kinds and widths for the pack-info header parser.
`timescale 1ns / 1ps

package apip_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned NUM_W   = 64;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned CNT_W   = 4;

    localparam logic [BYTE_W-1:0] ID_PACK_INFO = 8'h06;
    localparam logic [BYTE_W-1:0] ID_SIZES     = 8'h09;
    localparam logic [BYTE_W-1:0] ID_END       = 8'h00;
    localparam logic [BYTE_W-1:0] ID_CRC       = 8'h0a;
    localparam logic [BYTE_W-1:0] TOP_BIT      = 8'h80;

    typedef enum logic [KIND_W-1:0] {
        KIND_PACK_POS  = 3'd0,
        KIND_STREAM_CNT = 3'd1,
        KIND_PACK_SIZE = 3'd2,
        KIND_END_OK    = 3'd3,
        KIND_BAD_END   = 3'd4
    } t_kind;

endpackage

// File: design/archive_pack_info_parser.sv
// A result appears on o_m_* in the cycle after the byte that completes it is accepted.
// Throughput: one header byte per cycle unless a held result stalls; each byte passes one registered parse step.
// A held result blocks input only while the receiver stalls: a new byte is taken whenever
// the result register is empty or is being drained in the same cycle.
// Reset (i_rst_n low, synchronous): parser returns to scanning, all counters clear,
// and no result is pending.
`timescale 1ns / 1ps

module archive_pack_info_parser
    import apip_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input byte stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [BYTE_W-1:0]     i_s_tdata,   // [7:0] data_byte
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [2*NUM_W-1:0]    o_m_tdata,   // [63:0] value, [127:64] stream_index
    output logic [KIND_W-1:0]     o_m_tuser    // [2:0] kind
);

    // Parse phases, in the order the record fields arrive.
    typedef enum logic [3:0] {
        PH_SCAN        = 4'd0,
        PH_POS_FIRST   = 4'd1,
        PH_POS_EXTRA   = 4'd2,
        PH_CNT_FIRST   = 4'd3,
        PH_CNT_EXTRA   = 4'd4,
        PH_ID          = 4'd5,
        PH_SIZE_FIRST  = 4'd6,
        PH_SIZE_EXTRA  = 4'd7,
        PH_AFTER_SIZES = 4'd8,
        PH_CRC_END     = 4'd9
    } t_phase;

    // Count leading one bits of a number's first byte (0..8).
    function automatic logic [CNT_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
        logic [CNT_W-1:0] n;
        logic             run;
        n   = '0;
        run = 1'b1;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            run = run & b[i];
            n   = n + {{(CNT_W-1){1'b0}}, run};
        end
        return n;
    endfunction

    // Parser state
    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_left,  n_left;     // extra bytes still to come
    logic [CNT_W-1:0]   r_shift, n_shift;    // extra bytes taken so far
    logic [BYTE_W-1:0]  r_high,  n_high;     // first-byte bits that sit above the extras
    logic [NUM_W-1:0]   r_acc,   n_acc;
    logic [NUM_W-1:0]   r_remain, n_remain;  // sizes still expected
    logic [NUM_W-1:0]   r_stream, n_stream;  // index of the next size

    // Result register
    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [NUM_W-1:0]   r_out_value;
    logic [NUM_W-1:0]   r_out_index;

    logic               s_accept;
    logic               emit;
    t_kind              emit_kind;
    logic [NUM_W-1:0]   emit_value;
    logic [NUM_W-1:0]   emit_index;

    // First-byte decode
    logic [CNT_W-1:0]   first_n;
    logic [BYTE_W-1:0]  first_high;
    logic               first_short;

    // Extra-byte merge
    logic [CNT_W-1:0]   extra_shift_nx;
    logic [CNT_W-1:0]   extra_left_nx;
    logic               extra_done;
    logic [NUM_W-1:0]   extra_acc;
    logic [NUM_W-1:0]   byte_wide;

    // Take a byte whenever the result slot is free or drains this cycle.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign byte_wide  = {{(NUM_W-BYTE_W){1'b0}}, i_s_tdata};

    always_comb begin
        first_n     = lead_ones(i_s_tdata);
        first_short = (first_n == '0);
        first_high  = (first_n < CNT_W'(BYTE_W)) ?
                      (i_s_tdata & (8'h7f >> first_n[2:0])) : '0;
    end

    // Drop the extra byte into its little-endian slot; on the last one, place the
    // first-byte high bits just above the extras unless all eight bytes were extras.
    always_comb begin
        extra_shift_nx = r_shift + 1'b1;
        extra_left_nx  = r_left - 1'b1;
        extra_done     = (extra_left_nx == '0);
        extra_acc      = r_acc | (byte_wide << {r_shift[2:0], 3'b000});
        if (extra_done && (extra_shift_nx < CNT_W'(8))) begin
            extra_acc = extra_acc |
                ({{(NUM_W-BYTE_W){1'b0}}, r_high} << {extra_shift_nx[2:0], 3'b000});
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_shift    = r_shift;
        n_high     = r_high;
        n_acc      = r_acc;
        n_remain   = r_remain;
        n_stream   = r_stream;
        emit       = 1'b0;
        emit_kind  = KIND_PACK_POS;
        emit_value = '0;
        emit_index = '0;

        case (r_phase)
            PH_POS_FIRST, PH_CNT_FIRST, PH_SIZE_FIRST: begin
                // Start a number: short form carries its value in the byte itself.
                n_high  = first_high;
                n_acc   = '0;
                n_shift = '0;
                n_left  = first_n;
                if (first_short) begin
                    emit       = 1'b1;
                    emit_value = byte_wide;
                end else begin
                    n_phase = (r_phase == PH_POS_FIRST) ? PH_POS_EXTRA :
                              (r_phase == PH_CNT_FIRST) ? PH_CNT_EXTRA : PH_SIZE_EXTRA;
                end
            end
            PH_POS_EXTRA, PH_CNT_EXTRA, PH_SIZE_EXTRA: begin
                n_acc   = extra_acc;
                n_shift = extra_shift_nx;
                n_left  = extra_left_nx;
                if (extra_done) begin
                    emit       = 1'b1;
                    emit_value = extra_acc;
                end
            end
            PH_ID: begin
                if (i_s_tdata == ID_SIZES) begin
                    n_stream = '0;
                    n_phase  = (r_remain == '0) ? PH_AFTER_SIZES : PH_SIZE_FIRST;
                end else begin
                    emit    = 1'b1;
                    n_phase = PH_SCAN;
                end
            end
            PH_AFTER_SIZES: begin
                if (i_s_tdata == ID_CRC) begin
                    n_phase = PH_CRC_END;
                end else begin
                    emit    = 1'b1;
                    n_phase = PH_SCAN;
                end
            end
            PH_CRC_END: begin
                emit    = 1'b1;
                n_phase = PH_SCAN;
            end
            default: begin
                n_phase = (i_s_tdata == ID_PACK_INFO) ? PH_POS_FIRST : PH_SCAN;
            end
        endcase

        // Finish the completed number according to which field it was.
        if (emit) begin
            case (r_phase)
                PH_POS_FIRST, PH_POS_EXTRA: begin
                    emit_kind = KIND_PACK_POS;
                    n_phase   = PH_CNT_FIRST;
                end
                PH_CNT_FIRST, PH_CNT_EXTRA: begin
                    emit_kind = KIND_STREAM_CNT;
                    n_remain  = emit_value;
                    n_phase   = PH_ID;
                end
                PH_SIZE_FIRST, PH_SIZE_EXTRA: begin
                    emit_kind  = KIND_PACK_SIZE;
                    emit_index = r_stream;
                    n_stream   = r_stream + 1'b1;
                    n_remain   = r_remain - 1'b1;
                    n_phase    = (r_remain == NUM_W'(1)) ? PH_AFTER_SIZES : PH_SIZE_FIRST;
                end
                default: begin
                    // End check: ID byte must be the end marker.
                    if (i_s_tdata == ID_END) begin
                        emit_kind  = KIND_END_OK;
                        emit_value = '0;
                    end else begin
                        emit_kind  = KIND_BAD_END;
                        emit_value = byte_wide;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SCAN;
            r_left   <= '0;
            r_shift  <= '0;
            r_high   <= '0;
            r_acc    <= '0;
            r_remain <= '0;
            r_stream <= '0;
        end else if (s_accept) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_shift  <= n_shift;
            r_high   <= n_high;
            r_acc    <= n_acc;
            r_remain <= n_remain;
            r_stream <= n_stream;
        end
    end

    // Result slot: load on an accepted byte, otherwise drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && emit) begin
            r_out_kind  <= emit_kind;
            r_out_value <= emit_value;
            r_out_index <= emit_index;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_index, r_out_value};
    assign o_m_tuser  = r_out_kind;

`ifndef ASSERT_OFF
    a_extra_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_POS_EXTRA || r_phase == PH_CNT_EXTRA || r_phase == PH_SIZE_EXTRA)
        |-> (r_left != '0))
        else $error("extra-byte phase with no bytes left");

    a_sizes_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIZE_FIRST || r_phase == PH_SIZE_EXTRA) |-> (r_remain != '0))
        else $error("size phase with no streams remaining");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_shift <= CNT_W'(8)) && (r_left <= CNT_W'(8)))
        else $error("extra-byte counters out of range");

    a_end_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_END_OK) |-> (r_out_value == '0))
        else $error("end-ok result with nonzero value");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_out_valid)
        else $error("input stalled with empty result slot");
`endif

endmodule

// File: verif/tb.sv
// Self-checking bench for the pack-info header parser: byte driver, result monitor, predictor.
`timescale 1ns / 1ps

module tb;
    import apip_pkg::*;

    localparam int unsigned RANDOM_BYTES = 650;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned MAX_PRINTED = 50;

    // Directed opener: noise, a one-stream record with CRC, a max-position record with
    // zero streams, and a record whose ID after the count is not the sizes ID.
    localparam logic [7:0] DIRECTED_HDR [29] = '{
        8'hff, 8'h06, 8'h7f, 8'h01, 8'h09, 8'hc1, 8'h34, 8'h12, 8'h0a, 8'h00,
        8'h06, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h00, 8'h09, 8'h0a, 8'h05,
        8'h06, 8'h00, 8'h80, 8'h00, 8'h0a
    };

    typedef enum logic [3:0] {
        PH_SCAN, PH_POS_FIRST, PH_POS_EXTRA, PH_CNT_FIRST, PH_CNT_EXTRA,
        PH_ID, PH_SIZE_FIRST, PH_SIZE_EXTRA, PH_AFTER_SIZES, PH_CRC_END
    } t_hdr_phase;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [63:0] stream_idx;
    } t_pack_result;

    typedef struct {
        logic [7:0] data;
        bit         hold;   // wait for all outstanding results before presenting
    } t_hdr_byte;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [BYTE_W-1:0]      i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [2*NUM_W-1:0]     o_m_tdata;   // [63:0] value, [127:64] stream_index
    logic [KIND_W-1:0]      o_m_tuser;   // [2:0] kind

    archive_pack_info_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    t_hdr_byte    header_bytes[$];
    t_pack_result pending_results[$];
    int unsigned  total_bytes = 0;
    int unsigned  bytes_taken = 0;
    int unsigned  drain_holds = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  kind_seen[5] = '{default: 0};

    // Predictor state
    t_hdr_phase   phase_q = PH_SCAN;
    logic [3:0]   extra_left = '0;
    logic [3:0]   extra_taken = '0;
    logic [7:0]   hi_bits = '0;
    logic [63:0]  num_acc = '0;
    logic [63:0]  streams_left = '0;
    logic [63:0]  cur_stream = '0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void queue_result(input t_kind k, input logic [63:0] v,
                                         input logic [63:0] idx);
        t_pack_result r;
        r.kind = k;
        r.value = v;
        r.stream_idx = idx;
        pending_results.push_back(r);
    endfunction

    // Count leading ones of the first byte; keep the bits below the first zero.
    function automatic int unsigned start_number(input logic [7:0] b);
        int unsigned n = 0;
        while (n < 8 && b[7-n])
            n++;
        hi_bits = (n < 8) ? (b & (8'h7f >> n)) : 8'h00;
        num_acc = '0;
        extra_taken = '0;
        extra_left = n[3:0];
        return n;
    endfunction

    // Fold one little-endian extra byte; true when the number is complete.
    function automatic bit take_extra(input logic [7:0] b);
        num_acc |= 64'(b) << (8 * extra_taken[2:0]);
        extra_taken++;
        extra_left--;
        if (extra_left != 0)
            return 1'b0;
        if (extra_taken < 8)
            num_acc |= 64'(hi_bits) << (8 * extra_taken);
        return 1'b1;
    endfunction

    function automatic void close_count(input logic [63:0] v);
        streams_left = v;
        phase_q = PH_ID;
        queue_result(KIND_STREAM_CNT, v, '0);
    endfunction

    function automatic void close_size(input logic [63:0] v);
        queue_result(KIND_PACK_SIZE, v, cur_stream);
        cur_stream++;
        streams_left--;
        phase_q = (streams_left == 0) ? PH_AFTER_SIZES : PH_SIZE_FIRST;
    endfunction

    function automatic void close_record(input logic [7:0] b);
        phase_q = PH_SCAN;
        if (b == ID_END)
            queue_result(KIND_END_OK, '0, '0);
        else
            queue_result(KIND_BAD_END, 64'(b), '0);
    endfunction

    function automatic void parse_header_byte(input logic [7:0] b);
        case (phase_q)
            PH_POS_FIRST: begin
                if (start_number(b) == 0) begin
                    phase_q = PH_CNT_FIRST;
                    queue_result(KIND_PACK_POS, 64'(b), '0);
                end else begin
                    phase_q = PH_POS_EXTRA;
                end
            end
            PH_POS_EXTRA: begin
                if (take_extra(b)) begin
                    phase_q = PH_CNT_FIRST;
                    queue_result(KIND_PACK_POS, num_acc, '0);
                end
            end
            PH_CNT_FIRST: begin
                if (start_number(b) == 0)
                    close_count(64'(b));
                else
                    phase_q = PH_CNT_EXTRA;
            end
            PH_CNT_EXTRA: begin
                if (take_extra(b))
                    close_count(num_acc);
            end
            PH_ID: begin
                if (b == ID_SIZES) begin
                    cur_stream = '0;
                    phase_q = (streams_left == 0) ? PH_AFTER_SIZES : PH_SIZE_FIRST;
                end else begin
                    close_record(b);
                end
            end
            PH_SIZE_FIRST: begin
                if (start_number(b) == 0)
                    close_size(64'(b));
                else
                    phase_q = PH_SIZE_EXTRA;
            end
            PH_SIZE_EXTRA: begin
                if (take_extra(b))
                    close_size(num_acc);
            end
            PH_AFTER_SIZES: begin
                if (b == ID_CRC)
                    phase_q = PH_CRC_END;
                else
                    close_record(b);
            end
            PH_CRC_END: close_record(b);
            default: phase_q = (b == ID_PACK_INFO) ? PH_POS_FIRST : PH_SCAN;
        endcase
    endfunction

    // Stimulus helpers
    function automatic int unsigned pick_len();
        int unsigned r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 75) return $urandom_range(2, 1);
        if (r < 92) return $urandom_range(7, 3);
        return 8;
    endfunction

    function automatic void add_number(ref logic [7:0] rec[$], input int unsigned n_extra);
        logic [7:0] ones = 8'hff << (8 - n_extra);
        rec.push_back(ones | (8'($urandom) & (8'h7f >> n_extra)));
        repeat (n_extra) rec.push_back(8'($urandom));
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b = 8'($urandom);
        return (b == ID_PACK_INFO) ? 8'h66 : b;
    endfunction

    function automatic void flush_record(ref logic [7:0] rec[$], input bit hold);
        t_hdr_byte hb;
        foreach (rec[i]) begin
            hb.data = rec[i];
            hb.hold = hold && (i == 0);
            header_bytes.push_back(hb);
        end
        if (hold)
            drain_holds++;
    endfunction

    // Mostly well-formed records with random content; some noise and cut-off records.
    // The closing huge-count record adds roughly a hundred bytes on top of the goal.
    task automatic build_random_stream(input int unsigned n_bytes);
        logic [7:0]  rec[$];
        int unsigned goal;
        int unsigned roll;
        int unsigned n_streams;
        bit          first = 1'b1;
        goal = n_bytes - 130;
        while (header_bytes.size() < goal) begin
            rec.delete();
            roll = $urandom_range(99);
            if (roll < 10) begin
                repeat ($urandom_range(4, 1)) rec.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(2)) rec.push_back(noise_byte());
                rec.push_back(ID_PACK_INFO);
                add_number(rec, pick_len());
                roll = $urandom_range(99);
                if (roll < 15) begin
                    n_streams = 0;
                    rec.push_back(8'h00);
                end else if (roll < 85) begin
                    n_streams = $urandom_range(4, 1);
                    rec.push_back(8'(n_streams));
                end else begin
                    n_streams = $urandom_range(3, 1);
                    rec.push_back(TOP_BIT);
                    rec.push_back(8'(n_streams));
                end
                if ($urandom_range(99) < 80) begin
                    rec.push_back(ID_SIZES);
                    repeat (n_streams) add_number(rec, pick_len());
                end
                if ($urandom_range(1))
                    rec.push_back(ID_CRC);
                rec.push_back(($urandom_range(99) < 85) ? ID_END : 8'($urandom));
                // Cut the record short now and then; the next one lands mid-parse.
                if ($urandom_range(99) < 12)
                    rec = rec[0:$urandom_range(rec.size() - 1)];
            end
            flush_record(rec, first || ($urandom_range(19) == 0));
            first = 1'b0;
        end
        // Close with a huge stream count: the sizes run on to the end of the stimulus.
        rec.delete();
        rec.push_back(ID_PACK_INFO);
        rec.push_back(8'h00);
        rec.push_back(8'hff);
        repeat (7) rec.push_back(8'($urandom));
        rec.push_back(TOP_BIT | 8'($urandom));
        rec.push_back(ID_SIZES);
        repeat (30) add_number(rec, pick_len());
        flush_record(rec, 1'b1);
    endtask

    // Throttle: sender 14/receiver 54, then swapped, then full rate.
    function automatic int unsigned send_idle_pct();
        case ((bytes_taken * 3) / total_bytes)
            0: return 14;
            1: return 54;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned recv_idle_pct();
        case ((bytes_taken * 3) / total_bytes)
            0: return 54;
            1: return 14;
            default: return 0;
        endcase
    endfunction

    // Byte driver
    always @(posedge i_clk) begin : drive_bytes
        bit        busy;
        t_hdr_byte nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            busy = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                parse_header_byte(i_s_tdata);
                bytes_taken++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (header_bytes.size() != 0
                    && !(header_bytes[0].hold && pending_results.size() != 0)
                    && $urandom_range(99) >= send_idle_pct()) begin
                    nxt = header_bytes.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= nxt.data;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : watch_results
        t_pack_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d value %h",
                                              o_m_tuser, o_m_tdata[63:0]));
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tuser < 5)
                        kind_seen[o_m_tuser]++;
                    if (o_m_tuser !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  o_m_tuser, want.kind));
                    if (o_m_tdata[63:0] !== want.value)
                        report_mismatch($sformatf("value %h, want %h (kind %0d)",
                                                  o_m_tdata[63:0], want.value, want.kind));
                    if (o_m_tdata[127:64] !== want.stream_idx)
                        report_mismatch($sformatf("stream index %h, want %h",
                                                  o_m_tdata[127:64], want.stream_idx));
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    initial begin
        t_hdr_byte hb;
        foreach (DIRECTED_HDR[i]) begin
            hb.data = DIRECTED_HDR[i];
            hb.hold = 1'b0;
            header_bytes.push_back(hb);
        end
        build_random_stream(RANDOM_BYTES);
        total_bytes = header_bytes.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != total_bytes)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run: %0d header bytes, %0d pauses for a drained result queue.",
                 total_bytes, drain_holds);
        $display("Results: %0d positions, %0d counts, %0d sizes, %0d ok ends, %0d bad ends.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("TIMEOUT: %0d of %0d bytes taken, %0d results outstanding",
                 bytes_taken, total_bytes, pending_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule
